// ----- rtl/lbb_pkg.sv -----
// lbb_pkg: shared types, field widths, codes and reset values for the
// length bucket batcher. No dependencies; used by every rtl/lbb_* module but lbb_ram.
package lbb_pkg;

  // default sizing, taken as the defaults of the top level parameters
  localparam int DEF_NUM_BUCKETS = 4;
  localparam int DEF_MAX_BATCH   = 16;
  localparam int DEF_TAG_BITS    = 32;
  localparam int DEF_LEN_BITS    = 16;

  // fixed field widths of the channels
  localparam int FUNC_W     = 2;
  localparam int TAG_W      = 32;
  localparam int LEN_W      = 16;
  localparam int BKT_W      = 2;
  localparam int USE_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int FLD_W      = 16;  // one bound or batch size inside a packed register

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_ITEM  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EOS   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEN_BOUNDS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKETS_USED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_LEFTOVER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_TOO_LONG = 3'd5;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] RST_LEN_BOUNDS  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] RST_BATCH_SIZES = 64'h0010_0010_0010_0010;
  localparam logic [USE_W-1:0]      RST_BUCKETS_USED = 3'd4;
  localparam logic [LEN_W-1:0]      RST_MAX_LENGTH  = 16'hFFFF;

  // result status codes
  localparam logic STATUS_MEMBER  = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] len_bounds;
    logic [CFG_DATA_W-1:0] batch_sizes;
    logic [USE_W-1:0]      buckets_in_use;
    logic [LEN_W-1:0]      max_length;
    logic                  drop_leftovers;
    logic                  drop_too_long;
  } cfg_t;

  // what the sequencer does with one accepted item
  typedef enum logic [2:0] {
    K_NOP,
    K_ADD,
    K_ERR,
    K_EOS,
    K_CLR
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [BKT_W-1:0] bucket;
  } cmd_t;

endpackage

// ----- rtl/length_bucket_batcher.sv -----
// length_bucket_batcher: top level. Configuration registers, item classifier
// and bucket sequencer. Uses lbb_pkg, lbb_classify, lbb_seq (and lbb_ram).
//
// Groups sequence tags into batches by length. Each accepted item is
// classified on acceptance and executed in the execute state, from which
// an add that does not complete a batch, a clear, a dropped item or a
// too-long error goes back to idle; an error waits there while the result
// register is full. Each batch member read out of the bucket store takes a
// store read and a load into the result register, paced by the single read
// port of the store and the result register, for a completed batch and for
// an end-of-stream flush alike. The result register lets a finished result
// wait for result_ready while the block goes back to idle and takes the
// next item. Configuration writes are always ready and should be made only
// while the block is idle. The store needs no clearing after reset.
module length_bucket_batcher #(
  parameter int NUM_BUCKETS = lbb_pkg::DEF_NUM_BUCKETS,
  parameter int MAX_BATCH   = lbb_pkg::DEF_MAX_BATCH,
  parameter int TAG_BITS    = lbb_pkg::DEF_TAG_BITS,
  parameter int LEN_BITS    = lbb_pkg::DEF_LEN_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [lbb_pkg::FUNC_W-1:0]      func,
  input  logic [lbb_pkg::TAG_W-1:0]       item_tag,
  input  logic [lbb_pkg::LEN_W-1:0]       seq_len,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            status,
  output logic [lbb_pkg::BKT_W-1:0]       bucket_index,
  output logic [lbb_pkg::TAG_W-1:0]       out_tag,
  output logic                            batch_end,
  output logic                            last
);

  import lbb_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.len_bounds     <= RST_LEN_BOUNDS;
      cfg.batch_sizes    <= RST_BATCH_SIZES;
      cfg.buckets_in_use <= RST_BUCKETS_USED;
      cfg.max_length     <= RST_MAX_LENGTH;
      cfg.drop_leftovers <= 1'b0;
      cfg.drop_too_long  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEN_BOUNDS:    cfg.len_bounds     <= cfg_data;
        REG_BATCH_SIZES:   cfg.batch_sizes    <= cfg_data;
        REG_BUCKETS_USED:  cfg.buckets_in_use <= cfg_data[USE_W-1:0];
        REG_MAX_LENGTH:    cfg.max_length     <= cfg_data[LEN_W-1:0];
        REG_DROP_LEFTOVER: cfg.drop_leftovers <= cfg_data[0];
        REG_DROP_TOO_LONG: cfg.drop_too_long  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lbb_classify #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .LEN_BITS    (LEN_BITS)
  ) u_classify (
    .cfg     (cfg),
    .func    (func),
    .seq_len (seq_len),
    .cmd     (cmd)
  );

  lbb_seq #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .MAX_BATCH   (MAX_BATCH),
    .TAG_BITS    (TAG_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .cmd_in       (cmd),
    .tag_in       (item_tag),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .bucket_index (bucket_index),
    .out_tag      (out_tag),
    .batch_end    (batch_end),
    .last         (last)
  );

endmodule

// ----- rtl/lbb_ram.sv -----
// lbb_ram: generic single-clock RAM, one write port, one read port with
// registered read data. No dependencies.
module lbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/lbb_classify.sv -----
// lbb_classify: decodes an incoming item into a sequencer command: length
// check, first covering enabled bucket, function decode. Uses lbb_pkg.
module lbb_classify #(
  parameter int NUM_BUCKETS = lbb_pkg::DEF_NUM_BUCKETS,
  parameter int LEN_BITS    = lbb_pkg::DEF_LEN_BITS
) (
  input  lbb_pkg::cfg_t                    cfg,
  input  logic [lbb_pkg::FUNC_W-1:0]       func,
  input  logic [lbb_pkg::LEN_W-1:0]        seq_len,
  output lbb_pkg::cmd_t                    cmd
);

  import lbb_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MASK = LEN_W'((32'd1 << LEN_BITS) - 32'd1);

  logic [LEN_W-1:0] len;
  logic [USE_W-1:0] used;
  logic             hit;
  logic [BKT_W-1:0] sel;

  assign len  = seq_len & LEN_MASK;
  assign used = (cfg.buckets_in_use > USE_W'(NUM_BUCKETS)) ? USE_W'(NUM_BUCKETS)
                                                          : cfg.buckets_in_use;

  // walk downward so the lowest covering bucket wins
  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int b = NUM_BUCKETS - 1; b >= 0; b--) begin
      if ((USE_W'(b) < used) && (len <= cfg.len_bounds[FLD_W*b +: FLD_W])) begin
        hit = 1'b1;
        sel = BKT_W'(b);
      end
    end
  end

  always_comb begin
    cmd.bucket = sel;
    case (func)
      FUNC_ITEM: begin
        if (len > cfg.max_length) begin
          cmd.kind = cfg.drop_too_long ? K_NOP : K_ERR;
        end else begin
          cmd.kind = hit ? K_ADD : K_NOP;
        end
      end
      FUNC_EOS:   cmd.kind = K_EOS;
      FUNC_CLEAR: cmd.kind = K_CLR;
      default:    cmd.kind = K_NOP;
    endcase
  end

endmodule

// ----- rtl/lbb_seq.sv -----
// lbb_seq: bucket sequencer. Holds fill counts, writes tags into the bucket
// store RAM, drains full or flushed buckets into the result register.
// Uses lbb_pkg and lbb_ram.
module lbb_seq #(
  parameter int NUM_BUCKETS = lbb_pkg::DEF_NUM_BUCKETS,
  parameter int MAX_BATCH   = lbb_pkg::DEF_MAX_BATCH,
  parameter int TAG_BITS    = lbb_pkg::DEF_TAG_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lbb_pkg::cfg_t              cfg,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  lbb_pkg::cmd_t              cmd_in,
  input  logic [lbb_pkg::TAG_W-1:0]  tag_in,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic                       status,
  output logic [lbb_pkg::BKT_W-1:0]  bucket_index,
  output logic [lbb_pkg::TAG_W-1:0]  out_tag,
  output logic                       batch_end,
  output logic                       last
);

  import lbb_pkg::*;

  localparam int STORE_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int DEPTH   = NUM_BUCKETS * MAX_BATCH;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W   = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int FILL_W  = $clog2(MAX_BATCH + 1);
  localparam int BSEL_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } state_t;

  state_t               state;
  cmd_t                 cmd;
  logic [STORE_W-1:0]   tag;
  logic [FILL_W-1:0]    fill [NUM_BUCKETS];
  logic [BSEL_W-1:0]    dbkt;
  logic [IDX_W-1:0]     idx;
  logic [FILL_W-1:0]    dcnt;
  logic [NUM_BUCKETS-1:0] pending;

  logic [BSEL_W-1:0]    cb;
  logic [FILL_W-1:0]    cur_fill;
  logic [FLD_W-1:0]     bs_raw;
  logic [FILL_W-1:0]    bsize;
  logic                 room;
  logic [FILL_W-1:0]    new_fill;
  logic [NUM_BUCKETS-1:0] nonempty;
  logic [BSEL_W-1:0]    eos_first;
  logic [BSEL_W-1:0]    next_bkt;
  logic                 out_free;
  logic                 at_end;
  logic                 res_load;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic                 re;
  logic [ADDR_W-1:0]    raddr;
  logic [STORE_W-1:0]   rdata;

  function automatic logic [BSEL_W-1:0] lowest(input logic [NUM_BUCKETS-1:0] m);
    logic [BSEL_W-1:0] r;
    r = '0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = BSEL_W'(i);
      end
    end
    return r;
  endfunction

  assign cb       = cmd.bucket[BSEL_W-1:0];
  assign cur_fill = fill[cb];
  assign bs_raw   = cfg.batch_sizes[FLD_W*cb +: FLD_W];
  // size 0 acts as 1, sizes past MAX_BATCH (one bucket's store depth) saturate
  assign bsize    = (bs_raw == '0) ? FILL_W'(1) :
                    (bs_raw > FLD_W'(MAX_BATCH)) ? FILL_W'(MAX_BATCH) : bs_raw[FILL_W-1:0];
  assign room     = cur_fill < FILL_W'(MAX_BATCH);
  assign new_fill = room ? cur_fill + FILL_W'(1) : cur_fill;

  always_comb begin
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      nonempty[b] = fill[b] != '0;
    end
  end

  assign eos_first = lowest(nonempty);
  assign next_bkt  = lowest(pending);
  assign out_free  = !result_valid || result_ready;
  assign at_end    = (FILL_W'(idx) + FILL_W'(1)) == dcnt;

  // result register takes a new result on an error or a member load
  assign res_load  = ((state == S_EXEC) && (cmd.kind == K_ERR) && out_free) ||
                     (state == S_LOAD);

  assign item_ready = state == S_IDLE;

  assign we    = (state == S_EXEC) && (cmd.kind == K_ADD) && room;
  assign waddr = ADDR_W'(cb) * ADDR_W'(MAX_BATCH) + ADDR_W'(cur_fill[IDX_W-1:0]);
  assign re    = (state == S_READ) && out_free;
  assign raddr = ADDR_W'(dbkt) * ADDR_W'(MAX_BATCH) + ADDR_W'(idx);

  lbb_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (tag),
    .rd_en   (re),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      pending      <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        fill[b] <= '0;
      end
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cmd   <= cmd_in;
            tag   <= tag_in[STORE_W-1:0];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd.kind)
            K_ADD: begin
              if (new_fill >= bsize) begin
                // fill is cleared once the batch has drained
                dbkt    <= cb;
                dcnt    <= new_fill;
                idx     <= '0;
                pending <= '0;
                state   <= S_READ;
              end else begin
                fill[cb] <= new_fill;
                state    <= S_IDLE;
              end
            end
            K_ERR: begin
              if (out_free) begin
                status       <= STATUS_TOO_LONG;
                bucket_index <= '0;
                out_tag      <= TAG_W'(tag);
                batch_end    <= 1'b1;
                last         <= 1'b1;
                state        <= S_IDLE;
              end
            end
            K_EOS: begin
              if (cfg.drop_leftovers || (nonempty == '0)) begin
                for (int b = 0; b < NUM_BUCKETS; b++) begin
                  fill[b] <= '0;
                end
                state <= S_IDLE;
              end else begin
                dbkt    <= eos_first;
                dcnt    <= fill[eos_first];
                idx     <= '0;
                pending <= nonempty & ~(NUM_BUCKETS'(1) << eos_first);
                state   <= S_READ;
              end
            end
            K_CLR: begin
              for (int b = 0; b < NUM_BUCKETS; b++) begin
                fill[b] <= '0;
              end
              state <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_READ: begin
          // the read is issued only while the result register is free, so the load can take it
          if (out_free) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          status       <= STATUS_MEMBER;
          bucket_index <= BKT_W'(dbkt);
          out_tag      <= TAG_W'(rdata);
          batch_end    <= at_end;
          last         <= at_end && (pending == '0);
          if (at_end) begin
            fill[dbkt] <= '0;
            if (pending != '0) begin
              dbkt    <= next_bkt;
              dcnt    <= fill[next_bkt];
              idx     <= '0;
              pending <= pending & ~(NUM_BUCKETS'(1) << next_bkt);
              state   <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
